/* hw/rtl/mpjs_pkg.sv */
package mpjs_pkg;

   // Sizes of the job table and of the stored fields.
   localparam int SLOTS     = 64;
   localparam int ID_BITS   = $clog2(SLOTS);
   localparam int LEN_BITS  = $clog2(SLOTS) + 1;
   localparam int TIME_BITS = 32;
   localparam int PRIO_BITS = 16;
   localparam int SUM_BITS  = 48;
   localparam int CNT_BITS  = 32;

   // Scheduling policies.
   localparam logic [2:0] POL_FCFS  = 3'd0;
   localparam logic [2:0] POL_PRI   = 3'd1;
   localparam logic [2:0] POL_PPRI  = 3'd2;
   localparam logic [2:0] POL_PSRTF = 3'd3;
   localparam logic [2:0] POL_RR    = 3'd4;
   localparam logic [2:0] POL_SJF   = 3'd5;

   // Request actions.
   localparam logic [1:0] ACT_NEW    = 2'd0;
   localparam logic [1:0] ACT_QUANT  = 2'd1;
   localparam logic [1:0] ACT_FINISH = 2'd2;

   // Operations broadcast to the queue cells.
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_UPDATE = 2'd1;
   localparam logic [1:0] CELL_INSERT = 2'd2;
   localparam logic [1:0] CELL_POP    = 2'd3;

   // One queue entry with copies of its sort keys.
   typedef struct packed {
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] arr;
      logic [TIME_BITS-1:0] len;
      logic [TIME_BITS-1:0] rem;
      logic [PRIO_BITS-1:0] prio;
   } entry_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic [1:0] op;
      logic [2:0] policy;
      entry_type  ent;
   } cell_ctrl_type;

   // Per-slot job record held in the record memory.
   typedef struct packed {
      logic [TIME_BITS-1:0] arr;
      logic [TIME_BITS-1:0] len;
      logic [TIME_BITS-1:0] rem;
      logic [PRIO_BITS-1:0] prio;
      logic [TIME_BITS-1:0] fs;
      logic                 started;
      logic [TIME_BITS-1:0] ss;
      logic                 so;
   } rec_type;

   // Difference that floors at zero.
   function automatic logic [TIME_BITS-1:0] sub_floor(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
      return (a >= b) ? (a - b) : '0;
   endfunction

   // Running sum that sticks at its largest value.
   function automatic logic [SUM_BITS-1:0] add_sat(input logic [SUM_BITS-1:0] s,
                                                   input logic [TIME_BITS-1:0] v);
      logic [SUM_BITS:0] r;
      r = {1'b0, s} + {{(SUM_BITS + 1 - TIME_BITS){1'b0}}, v};
      return r[SUM_BITS] ? '1 : r[SUM_BITS-1:0];
   endfunction

   // True if entry x must be served strictly before entry y.
   function automatic logic precedes(input logic [2:0] pol, input entry_type x,
                                     input entry_type y);
      logic [TIME_BITS-1:0] kx;
      logic [TIME_BITS-1:0] ky;
      logic                 res;
      kx  = '0;
      ky  = '0;
      res = 1'b0;
      unique case (pol)
         POL_RR: begin
            res = 1'b0;
         end
         POL_PRI, POL_PPRI: begin
            kx  = {{(TIME_BITS-PRIO_BITS){1'b0}}, x.prio};
            ky  = {{(TIME_BITS-PRIO_BITS){1'b0}}, y.prio};
            res = (kx != ky) ? (kx < ky) : (x.arr < y.arr);
         end
         POL_PSRTF: begin
            res = (x.rem != y.rem) ? (x.rem < y.rem) : (x.arr < y.arr);
         end
         POL_SJF: begin
            res = (x.len != y.len) ? (x.len < y.len) : (x.arr < y.arr);
         end
         default: begin
            res = x.arr < y.arr;
         end
      endcase
      return res;
   endfunction

endpackage

/* hw/rtl/mpjs_ram.sv */
module mpjs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port, registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/mpjs_cell.sv */
module mpjs_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  mpjs_pkg::cell_ctrl_type ctrl,
   input  mpjs_pkg::entry_type    left_ent,
   input  logic                   left_valid,
   input  mpjs_pkg::entry_type    right_ent,
   input  logic                   right_valid,
   input  logic                   take_left,
   input  logic                   hit,
   output mpjs_pkg::entry_type    ent,
   output logic                   valid,
   output logic                   prec
);

   mpjs_pkg::entry_type ent_ff;
   logic                valid_ff;

   // Flags that the new entry precedes this one or that this cell is free; the first flagged cell takes it.
   assign prec  = !valid_ff || mpjs_pkg::precedes(ctrl.policy, ctrl.ent, ent_ff);
   assign ent   = ent_ff;
   assign valid = valid_ff;

   // Shift, insert, pop or refresh the keys of a rewritten slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         unique case (ctrl.op)
            mpjs_pkg::CELL_UPDATE: begin
               if (valid_ff && ent_ff.id == ctrl.ent.id) begin
                  ent_ff <= ctrl.ent;
               end
            end
            mpjs_pkg::CELL_INSERT: begin
               if (take_left) begin
                  ent_ff   <= left_ent;
                  valid_ff <= left_valid;
               end else if (hit) begin
                  ent_ff   <= ctrl.ent;
                  valid_ff <= 1'b1;
               end
            end
            mpjs_pkg::CELL_POP: begin
               ent_ff   <= right_ent;
               valid_ff <= right_valid;
            end
            default: begin
               ent_ff <= ent_ff;
            end
         endcase
      end
   end

endmodule

/* hw/rtl/multi_policy_job_scheduler.sv */
// Job scheduler with a policy-ordered ready queue.
// Request channel: a transfer happens when start is high and busy is low;
// req_action selects a new job, a quantum expiry or a job finish.
// Response channel: rsp_valid is high for one cycle per request and the
// rsp_ fields are valid in that cycle; the receiver cannot stall it.
// Configuration: csr_we writes the policy from csr_wdata; write only while
// busy is low.
// A new job passes S_UPD, S_CMP and S_INS; a quantum expiry goes straight
// to S_OUT if the running job is kept, else requeues any evicted job via
// S_RDQ and those states and dispatches via S_POP and S_PRD; a finish
// passes S_FIN1 to S_FIN3; every request ends in S_OUT. Busy stays high
// until that response cycle is over, so requests go one at a time; the
// single-port record memory and the cell-row compare shape each sequence.
// Reset empties the queue, clears the totals, the arrival count and the
// policy; per-slot records are undefined until a job arrives in that slot.
module multi_policy_job_scheduler (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_action,
   input  logic [mpjs_pkg::ID_BITS-1:0]    req_job_id,
   input  logic [mpjs_pkg::TIME_BITS-1:0]  req_now,
   input  logic [mpjs_pkg::TIME_BITS-1:0]  req_run_length,
   input  logic [mpjs_pkg::PRIO_BITS-1:0]  req_prio,
   input  logic                            req_evicted_valid,
   input  logic [mpjs_pkg::ID_BITS-1:0]    req_evicted_id,
   input  logic                            csr_we,
   input  logic [2:0]                      csr_wdata,
   output logic                            rsp_valid,
   output logic                            rsp_chosen_valid,
   output logic [mpjs_pkg::ID_BITS-1:0]    rsp_chosen_id,
   output logic                            rsp_queue_full,
   output logic [mpjs_pkg::SUM_BITS-1:0]   rsp_turnaround_total,
   output logic [mpjs_pkg::SUM_BITS-1:0]   rsp_waiting_total,
   output logic [mpjs_pkg::SUM_BITS-1:0]   rsp_response_total,
   output logic [mpjs_pkg::CNT_BITS-1:0]   rsp_arrived_count
);

   localparam int N  = mpjs_pkg::SLOTS;
   localparam int TB = mpjs_pkg::TIME_BITS;
   localparam int SB = mpjs_pkg::SUM_BITS;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RDQ  = 4'd1;
   localparam logic [3:0] S_UPD  = 4'd2;
   localparam logic [3:0] S_CMP  = 4'd3;
   localparam logic [3:0] S_INS  = 4'd4;
   localparam logic [3:0] S_POP  = 4'd5;
   localparam logic [3:0] S_PRD  = 4'd6;
   localparam logic [3:0] S_FIN1 = 4'd7;
   localparam logic [3:0] S_FIN2 = 4'd8;
   localparam logic [3:0] S_FIN3 = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;

   logic [3:0]                      state_ff;
   logic [3:0]                      state_in;
   logic [2:0]                      policy_ff;
   logic [1:0]                      action_ff;
   logic [TB-1:0]                   now_ff;
   logic [mpjs_pkg::ID_BITS-1:0]    ev_id_ff;
   mpjs_pkg::entry_type             ent_ff;
   mpjs_pkg::rec_type               rec_ff;
   logic [N-1:0]                    hit_ff;
   logic [mpjs_pkg::LEN_BITS-1:0]   qlen_ff;
   logic                            chosen_v_ff;
   logic [mpjs_pkg::ID_BITS-1:0]    chosen_ff;
   logic                            full_ff;
   logic [TB-1:0]                   turn_ff;
   logic [TB-1:0]                   wait_ff;
   logic [TB-1:0]                   resp_ff;
   logic [TB-1:0]                   flen_ff;
   logic                            fstarted_ff;
   logic [TB-1:0]                   ffs_ff;
   logic [TB-1:0]                   farr_ff;
   logic [SB-1:0]                   sum_turn_ff;
   logic [SB-1:0]                   sum_wait_ff;
   logic [SB-1:0]                   sum_resp_ff;
   logic [mpjs_pkg::CNT_BITS-1:0]   count_ff;

   logic                            accept;
   logic                            keep;
   logic                            q_full;
   logic                            q_empty;
   logic                            ram_we;
   logic [mpjs_pkg::ID_BITS-1:0]    ram_addr;
   mpjs_pkg::rec_type               ram_wdata;
   mpjs_pkg::rec_type               ram_rdata;
   mpjs_pkg::rec_type               rd_mod;
   mpjs_pkg::entry_type             ev_ent;
   logic [TB-1:0]                   ran;
   mpjs_pkg::cell_ctrl_type         ctrl;
   mpjs_pkg::entry_type             cell_ent [N];
   logic [N-1:0]                    cell_valid;
   logic [N-1:0]                    cell_prec;
   logic [N-1:0]                    take_left;

   assign accept  = start && (state_ff == S_IDLE);
   assign busy    = (state_ff != S_IDLE);
   assign keep    = !(policy_ff == mpjs_pkg::POL_PPRI || policy_ff == mpjs_pkg::POL_PSRTF ||
                      policy_ff == mpjs_pkg::POL_RR);
   assign q_full  = (qlen_ff == mpjs_pkg::LEN_BITS'(N));
   assign q_empty = (qlen_ff == '0);

   // Requeued job: charge the run slice under PSRTF and close it.
   always_comb begin
      ran    = mpjs_pkg::sub_floor(now_ff, ram_rdata.ss);
      rd_mod = ram_rdata;
      if (policy_ff == mpjs_pkg::POL_PSRTF && ram_rdata.so) begin
         rd_mod.rem = mpjs_pkg::sub_floor(ram_rdata.rem, ran);
         rd_mod.so  = 1'b0;
      end
      ev_ent.id   = ev_id_ff;
      ev_ent.arr  = rd_mod.arr;
      ev_ent.len  = rd_mod.len;
      ev_ent.rem  = rd_mod.rem;
      ev_ent.prio = rd_mod.prio;
   end

   // Record memory port selection.
   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = ent_ff.id;
      ram_wdata = rec_ff;
      unique case (state_ff)
         S_IDLE: begin
            ram_addr = (req_action == mpjs_pkg::ACT_QUANT) ? req_evicted_id : req_job_id;
         end
         S_UPD: begin
            ram_we = 1'b1;
         end
         S_POP: begin
            ram_addr = cell_ent[0].id;
         end
         S_PRD: begin
            ram_we    = 1'b1;
            ram_addr  = chosen_ff;
            ram_wdata = ram_rdata;
            if (!ram_rdata.started) begin
               ram_wdata.started = 1'b1;
               ram_wdata.fs      = now_ff;
            end
            if (policy_ff == mpjs_pkg::POL_PSRTF && !ram_rdata.so) begin
               ram_wdata.so = 1'b1;
               ram_wdata.ss = now_ff;
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   mpjs_ram #(
      .WIDTH ($bits(mpjs_pkg::rec_type)),
      .DEPTH (N)
   ) u_rec_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Cell row control.
   always_comb begin
      ctrl.policy = policy_ff;
      ctrl.ent    = ent_ff;
      ctrl.op     = mpjs_pkg::CELL_HOLD;
      if (state_ff == S_UPD) begin
         ctrl.op = mpjs_pkg::CELL_UPDATE;
      end else if (state_ff == S_INS && !q_full) begin
         ctrl.op = mpjs_pkg::CELL_INSERT;
      end else if (state_ff == S_POP && !q_empty) begin
         ctrl.op = mpjs_pkg::CELL_POP;
      end
   end

   // A cell shifts right when an earlier cell takes the new entry.
   always_comb begin
      take_left[0] = 1'b0;
      for (int i = 1; i < N; i++) begin
         take_left[i] = take_left[i-1] | hit_ff[i-1];
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_cell
      mpjs_pkg::entry_type left_ent;
      mpjs_pkg::entry_type right_ent;
      logic                left_valid;
      logic                right_valid;
      if (g == 0) begin : g_first
         assign left_ent   = ent_ff;
         assign left_valid = 1'b1;
      end else begin : g_mid_left
         assign left_ent   = cell_ent[g-1];
         assign left_valid = cell_valid[g-1];
      end
      if (g == N-1) begin : g_last
         assign right_ent   = cell_ent[g];
         assign right_valid = 1'b0;
      end else begin : g_mid_right
         assign right_ent   = cell_ent[g+1];
         assign right_valid = cell_valid[g+1];
      end
      mpjs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_ent    (left_ent),
         .left_valid  (left_valid),
         .right_ent   (right_ent),
         .right_valid (right_valid),
         .take_left   (take_left[g]),
         .hit         (hit_ff[g]),
         .ent         (cell_ent[g]),
         .valid       (cell_valid[g]),
         .prec        (cell_prec[g])
      );
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority case (req_action)
                  mpjs_pkg::ACT_NEW:    state_in = S_UPD;
                  mpjs_pkg::ACT_QUANT: begin
                     if (keep && req_evicted_valid) begin
                        state_in = S_OUT;
                     end else if (req_evicted_valid) begin
                        state_in = S_RDQ;
                     end else begin
                        state_in = S_POP;
                     end
                  end
                  mpjs_pkg::ACT_FINISH: state_in = S_FIN1;
                  default:              state_in = S_OUT;
               endcase
            end
         end
         S_RDQ:  state_in = S_UPD;
         S_UPD:  state_in = S_CMP;
         S_CMP:  state_in = S_INS;
         S_INS:  state_in = (action_ff == mpjs_pkg::ACT_NEW) ? S_OUT : S_POP;
         S_POP:  state_in = q_empty ? S_OUT : S_PRD;
         S_PRD:  state_in = S_OUT;
         S_FIN1: state_in = S_FIN2;
         S_FIN2: state_in = S_FIN3;
         S_FIN3: state_in = S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         policy_ff   <= mpjs_pkg::POL_FCFS;
         qlen_ff     <= '0;
         sum_turn_ff <= '0;
         sum_wait_ff <= '0;
         sum_resp_ff <= '0;
         count_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            policy_ff <= csr_wdata;
         end
         if (accept && req_action == mpjs_pkg::ACT_NEW && count_ff != '1) begin
            count_ff <= count_ff + 1'b1;
         end
         if (state_ff == S_INS && !q_full) begin
            qlen_ff <= qlen_ff + 1'b1;
         end else if (state_ff == S_POP && !q_empty) begin
            qlen_ff <= qlen_ff - 1'b1;
         end
         if (state_ff == S_FIN3) begin
            sum_turn_ff <= mpjs_pkg::add_sat(sum_turn_ff, turn_ff);
            sum_wait_ff <= mpjs_pkg::add_sat(sum_wait_ff, wait_ff);
            sum_resp_ff <= mpjs_pkg::add_sat(sum_resp_ff, resp_ff);
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      hit_ff <= cell_prec;
      if (accept) begin
         action_ff    <= req_action;
         now_ff       <= req_now;
         ev_id_ff     <= req_evicted_id;
         chosen_v_ff  <= req_action == mpjs_pkg::ACT_QUANT && keep && req_evicted_valid;
         chosen_ff    <= (req_action == mpjs_pkg::ACT_QUANT && keep && req_evicted_valid)
                         ? req_evicted_id : '0;
         full_ff      <= 1'b0;
         ent_ff.id    <= req_job_id;
         ent_ff.arr   <= req_now;
         ent_ff.len   <= req_run_length;
         ent_ff.rem   <= req_run_length;
         ent_ff.prio  <= req_prio;
         rec_ff.arr     <= req_now;
         rec_ff.len     <= req_run_length;
         rec_ff.rem     <= req_run_length;
         rec_ff.prio    <= req_prio;
         rec_ff.fs      <= '0;
         rec_ff.started <= 1'b0;
         rec_ff.ss      <= '0;
         rec_ff.so      <= 1'b0;
      end
      if (state_ff == S_RDQ) begin
         ent_ff <= ev_ent;
         rec_ff <= rd_mod;
      end
      if (state_ff == S_INS && q_full) begin
         full_ff <= 1'b1;
      end
      if (state_ff == S_POP && !q_empty) begin
         chosen_v_ff <= 1'b1;
         chosen_ff   <= cell_ent[0].id;
      end
      if (state_ff == S_FIN1) begin
         turn_ff     <= mpjs_pkg::sub_floor(now_ff, ram_rdata.arr);
         flen_ff     <= ram_rdata.len;
         fstarted_ff <= ram_rdata.started;
         ffs_ff      <= ram_rdata.fs;
         farr_ff     <= ram_rdata.arr;
      end
      if (state_ff == S_FIN2) begin
         wait_ff <= mpjs_pkg::sub_floor(turn_ff, flen_ff);
         resp_ff <= fstarted_ff ? mpjs_pkg::sub_floor(ffs_ff, farr_ff) : '0;
      end
   end

   // Response.
   assign rsp_valid            = (state_ff == S_OUT);
   assign rsp_chosen_valid     = chosen_v_ff;
   assign rsp_chosen_id        = chosen_ff;
   assign rsp_queue_full       = full_ff;
   assign rsp_turnaround_total = sum_turn_ff;
   assign rsp_waiting_total    = sum_wait_ff;
   assign rsp_response_total   = sum_resp_ff;
   assign rsp_arrived_count    = count_ff;

endmodule

/* hw/rtl/mpjs_checker.sv */
module mpjs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic                          rsp_chosen_valid,
   input logic [mpjs_pkg::ID_BITS-1:0]  rsp_chosen_id
);

   // A response only appears while a request is in flight.
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response outside a transfer");

   // An accepted request makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted request not busy");

   // The response cycle ends the request.
   a_rsp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid) else $error("response not closing request");

   // No dispatch shows a zero slot.
   a_chosen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_chosen_valid |-> rsp_chosen_id == '0)
      else $error("slot shown without dispatch");

   // After reset the block is idle.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy) else $error("busy after reset");

endmodule

bind multi_policy_job_scheduler mpjs_checker u_mpjs_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_chosen_valid (rsp_chosen_valid),
   .rsp_chosen_id    (rsp_chosen_id)
);

/* bench/tb.sv */
module tb;

   // Local copies of the package sizes.
   localparam int SLOTS     = mpjs_pkg::SLOTS;
   localparam int ID_BITS   = mpjs_pkg::ID_BITS;
   localparam int TIME_BITS = mpjs_pkg::TIME_BITS;
   localparam int PRIO_BITS = mpjs_pkg::PRIO_BITS;
   localparam int SUM_BITS  = mpjs_pkg::SUM_BITS;
   localparam int CNT_BITS  = mpjs_pkg::CNT_BITS;

   // Codes that the package leaves out.
   localparam logic [1:0] ACT_NONE    = 2'd3;
   localparam logic [2:0] POL_UNDEF_A = 3'd6;
   localparam logic [2:0] POL_UNDEF_B = 3'd7;
   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [1:0]           action;
      logic [ID_BITS-1:0]   job_id;
      logic [TIME_BITS-1:0] now;
      logic [TIME_BITS-1:0] run_length;
      logic [PRIO_BITS-1:0] prio;
      logic                 ev_valid;
      logic [ID_BITS-1:0]   ev_id;
   } sched_req_type;

   typedef struct {
      logic                 chosen_valid;
      logic [ID_BITS-1:0]   chosen_id;
      logic                 full;
      logic [SUM_BITS-1:0]  turn;
      logic [SUM_BITS-1:0]  wait_t;
      logic [SUM_BITS-1:0]  resp;
      logic [CNT_BITS-1:0]  arrived;
   } sched_rsp_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [1:0]           req_action;
   logic [ID_BITS-1:0]   req_job_id;
   logic [TIME_BITS-1:0] req_now;
   logic [TIME_BITS-1:0] req_run_length;
   logic [PRIO_BITS-1:0] req_prio;
   logic                 req_evicted_valid;
   logic [ID_BITS-1:0]   req_evicted_id;
   logic                 csr_we;
   logic [2:0]           csr_wdata;
   logic                 rsp_valid;
   logic                 rsp_chosen_valid;
   logic [ID_BITS-1:0]   rsp_chosen_id;
   logic                 rsp_queue_full;
   logic [SUM_BITS-1:0]  rsp_turnaround_total;
   logic [SUM_BITS-1:0]  rsp_waiting_total;
   logic [SUM_BITS-1:0]  rsp_response_total;
   logic [CNT_BITS-1:0]  rsp_arrived_count;

   multi_policy_job_scheduler uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_job_id(req_job_id), .req_now(req_now),
      .req_run_length(req_run_length), .req_prio(req_prio),
      .req_evicted_valid(req_evicted_valid), .req_evicted_id(req_evicted_id),
      .csr_we(csr_we), .csr_wdata(csr_wdata), .rsp_valid(rsp_valid),
      .rsp_chosen_valid(rsp_chosen_valid), .rsp_chosen_id(rsp_chosen_id),
      .rsp_queue_full(rsp_queue_full), .rsp_turnaround_total(rsp_turnaround_total),
      .rsp_waiting_total(rsp_waiting_total), .rsp_response_total(rsp_response_total),
      .rsp_arrived_count(rsp_arrived_count)
   );

   sched_req_type pending_jobs[$];
   sched_rsp_type expected_rsp[$];
   sched_req_type cur_req;
   int            idle_pct;
   int            mismatches;
   int            cycles;

   // Shadow state of the scheduler.
   logic [2:0]           m_policy;
   int                   m_queue[$];
   logic [TIME_BITS-1:0] m_arr[SLOTS];
   logic [TIME_BITS-1:0] m_len[SLOTS];
   logic [TIME_BITS-1:0] m_rem[SLOTS];
   logic [PRIO_BITS-1:0] m_prio[SLOTS];
   logic [TIME_BITS-1:0] m_fs[SLOTS];
   logic                 m_started[SLOTS];
   logic [TIME_BITS-1:0] m_ss[SLOTS];
   logic                 m_so[SLOTS];
   logic [SUM_BITS-1:0]  m_turn, m_wait, m_resp;
   logic [CNT_BITS-1:0]  m_seen;

   // Slots written by an arrival, tracked on the stimulus side.
   bit recorded[SLOTS];
   logic [TIME_BITS-1:0] gen_time;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [TIME_BITS-1:0] floor_diff(logic [TIME_BITS-1:0] a,
                                                       logic [TIME_BITS-1:0] b);
      return (a >= b) ? a - b : '0;
   endfunction

   function automatic logic [SUM_BITS-1:0] sat_add(logic [SUM_BITS-1:0] s,
                                                   logic [TIME_BITS-1:0] v);
      logic [SUM_BITS:0] r;
      r = {1'b0, s} + {{(SUM_BITS + 1 - TIME_BITS){1'b0}}, v};
      return r[SUM_BITS] ? SUM_MAX : r[SUM_BITS-1:0];
   endfunction

   // Strict service order of slot x over slot y under the current policy.
   function automatic bit served_first(int x, int y);
      logic [TIME_BITS-1:0] kx, ky;
      case (m_policy)
         mpjs_pkg::POL_RR: return 0;
         mpjs_pkg::POL_PRI, mpjs_pkg::POL_PPRI: begin
            kx = {{(TIME_BITS - PRIO_BITS){1'b0}}, m_prio[x]};
            ky = {{(TIME_BITS - PRIO_BITS){1'b0}}, m_prio[y]};
         end
         mpjs_pkg::POL_PSRTF: begin
            kx = m_rem[x];
            ky = m_rem[y];
         end
         mpjs_pkg::POL_SJF: begin
            kx = m_len[x];
            ky = m_len[y];
         end
         default: return m_arr[x] < m_arr[y];
      endcase
      if (kx != ky) return kx < ky;
      return m_arr[x] < m_arr[y];
   endfunction

   // Sorted insert after all equals; returns 1 when the queue is full.
   function automatic bit ready_insert(int slot);
      int pos;
      if (m_queue.size() >= SLOTS) return 1;
      pos = 0;
      while (pos < m_queue.size() && !served_first(slot, m_queue[pos])) pos++;
      m_queue.insert(pos, slot);
      return 0;
   endfunction

   // Applies one accepted transfer to the shadow state and queues its response.
   task automatic schedule_predict(sched_req_type r);
      sched_rsp_type e;
      bit keep;
      int c;
      logic [TIME_BITS-1:0] turn, wt, rs;
      e = '{default: '0};
      if (r.action == mpjs_pkg::ACT_NEW) begin
         m_arr[r.job_id] = r.now;
         m_len[r.job_id] = r.run_length;
         m_rem[r.job_id] = r.run_length;
         m_prio[r.job_id] = r.prio;
         m_started[r.job_id] = 0;
         m_fs[r.job_id] = '0;
         m_so[r.job_id] = 0;
         m_ss[r.job_id] = '0;
         e.full = ready_insert(int'(r.job_id));
         if (m_seen != '1) m_seen++;
      end else if (r.action == mpjs_pkg::ACT_QUANT) begin
         keep = m_policy == mpjs_pkg::POL_FCFS || m_policy == mpjs_pkg::POL_PRI ||
                m_policy >= mpjs_pkg::POL_SJF;
         if (keep && r.ev_valid) begin
            e.chosen_valid = 1;
            e.chosen_id = r.ev_id;
         end else begin
            if (!keep && r.ev_valid) begin
               if (m_policy == mpjs_pkg::POL_PSRTF && m_so[r.ev_id]) begin
                  m_rem[r.ev_id] = floor_diff(m_rem[r.ev_id],
                                              floor_diff(r.now, m_ss[r.ev_id]));
                  m_so[r.ev_id] = 0;
               end
               e.full = ready_insert(int'(r.ev_id));
            end
            if (m_queue.size() > 0) begin
               c = m_queue.pop_front();
               e.chosen_valid = 1;
               e.chosen_id = ID_BITS'(c);
               if (!m_started[c]) begin
                  m_started[c] = 1;
                  m_fs[c] = r.now;
               end
               if (m_policy == mpjs_pkg::POL_PSRTF && !m_so[c]) begin
                  m_so[c] = 1;
                  m_ss[c] = r.now;
               end
            end
         end
      end else if (r.action == mpjs_pkg::ACT_FINISH) begin
         turn = floor_diff(r.now, m_arr[r.job_id]);
         wt = floor_diff(turn, m_len[r.job_id]);
         rs = m_started[r.job_id] ? floor_diff(m_fs[r.job_id], m_arr[r.job_id]) : '0;
         m_turn = sat_add(m_turn, turn);
         m_wait = sat_add(m_wait, wt);
         m_resp = sat_add(m_resp, rs);
      end
      e.turn = m_turn;
      e.wait_t = m_wait;
      e.resp = m_resp;
      e.arrived = m_seen;
      expected_rsp.push_back(e);
   endtask

   // Driver: one transfer per accepted start, random gaps between them.
   always @(posedge clock) begin
      bit accepted;
      bit next_start;
      accepted = 0;
      next_start = start;
      if (reset) begin
         next_start = 0;
      end else begin
         if (start && !busy) begin
            schedule_predict(cur_req);
            accepted = 1;
            next_start = 0;
         end
         if ((!start || accepted) && pending_jobs.size() > 0 &&
             $urandom_range(99) >= idle_pct) begin
            cur_req = pending_jobs.pop_front();
            req_action <= cur_req.action;
            req_job_id <= cur_req.job_id;
            req_now <= cur_req.now;
            req_run_length <= cur_req.run_length;
            req_prio <= cur_req.prio;
            req_evicted_valid <= cur_req.ev_valid;
            req_evicted_id <= cur_req.ev_id;
            next_start = 1;
         end
      end
      start <= next_start;
   end

   // Monitor: each response strobe is checked against the oldest prediction.
   always @(posedge clock) begin
      sched_rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response transfer");
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_chosen_valid !== e.chosen_valid || rsp_chosen_id !== e.chosen_id ||
                rsp_queue_full !== e.full || rsp_turnaround_total !== e.turn ||
                rsp_waiting_total !== e.wait_t || rsp_response_total !== e.resp ||
                rsp_arrived_count !== e.arrived) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch exp cv=%0d id=%0d full=%0d tat=%0d wt=%0d rt=%0d n=%0d",
                           e.chosen_valid, e.chosen_id, e.full, e.turn, e.wait_t,
                           e.resp, e.arrived);
                  $display("         got cv=%0d id=%0d full=%0d tat=%0d wt=%0d rt=%0d n=%0d",
                           rsp_chosen_valid, rsp_chosen_id, rsp_queue_full,
                           rsp_turnaround_total, rsp_waiting_total, rsp_response_total,
                           rsp_arrived_count);
               end
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("multi_policy_job_scheduler regression: fail");
         $finish;
      end
   end

   function automatic int pick_recorded();
      int s;
      int tries;
      for (tries = 0; tries < 200; tries++) begin
         s = int'($urandom_range(SLOTS - 1));
         if (recorded[s]) return s;
      end
      for (s = 0; s < SLOTS; s++) if (recorded[s]) return s;
      return -1;
   endfunction

   task automatic add_item(logic [1:0] act, int id, logic [TIME_BITS-1:0] t,
                           logic [TIME_BITS-1:0] len, logic [PRIO_BITS-1:0] pr,
                           bit evv, int evid);
      sched_req_type r;
      r.action = act;
      r.job_id = ID_BITS'(id);
      r.now = t;
      r.run_length = len;
      r.prio = pr;
      r.ev_valid = evv;
      r.ev_id = ID_BITS'(evid);
      if (act == mpjs_pkg::ACT_NEW) recorded[id] = 1;
      pending_jobs.push_back(r);
   endtask

   // One random transfer; preemptive evictions and finishes use recorded slots only.
   task automatic add_random(int new_pct, bit keep_pol);
      int roll;
      int s;
      bit evv;
      logic [TIME_BITS-1:0] len;
      logic [PRIO_BITS-1:0] pr;
      roll = int'($urandom_range(99));
      gen_time += $urandom_range(40);
      if ($urandom_range(29) == 0) gen_time = $urandom;
      s = pick_recorded();
      len = ($urandom_range(9) == 0) ? $urandom : $urandom_range(60);
      pr = ($urandom_range(3) == 0) ? PRIO_BITS'($urandom) : PRIO_BITS'($urandom_range(3));
      if (s < 0 || roll < new_pct) begin
         add_item(mpjs_pkg::ACT_NEW, int'($urandom_range(SLOTS - 1)), gen_time, len, pr,
                  1'($urandom_range(1)), int'($urandom_range(SLOTS - 1)));
      end else if (roll < new_pct + (100 - new_pct) * 6 / 10) begin
         evv = $urandom_range(3) != 0;
         if (keep_pol && $urandom_range(1) != 0) s = int'($urandom_range(SLOTS - 1));
         add_item(mpjs_pkg::ACT_QUANT, int'($urandom_range(SLOTS - 1)), gen_time,
                  $urandom, PRIO_BITS'($urandom), evv, s);
      end else if (roll < 96) begin
         add_item(mpjs_pkg::ACT_FINISH, s, gen_time, $urandom, PRIO_BITS'($urandom),
                  1'($urandom_range(1)), int'($urandom_range(SLOTS - 1)));
      end else begin
         add_item(ACT_NONE, int'($urandom_range(SLOTS - 1)), $urandom, $urandom,
                  PRIO_BITS'($urandom), 1'($urandom_range(1)),
                  int'($urandom_range(SLOTS - 1)));
      end
   endtask

   task automatic drain();
      wait (pending_jobs.size() == 0 && expected_rsp.size() == 0 && !start);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_policy(logic [2:0] p);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= p;
      m_policy = p;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [2:0] pols[10];
      int idles[10];
      int news[10];
      int ph;
      int k;
      pols = '{mpjs_pkg::POL_PSRTF, mpjs_pkg::POL_FCFS, mpjs_pkg::POL_PRI,
               mpjs_pkg::POL_PPRI, mpjs_pkg::POL_RR, mpjs_pkg::POL_SJF, POL_UNDEF_B,
               mpjs_pkg::POL_PSRTF, POL_UNDEF_A, mpjs_pkg::POL_PPRI};
      idles = '{0, 0, 81, 13, 0, 81, 13, 0, 81, 0};
      news = '{45, 90, 45, 40, 85, 45, 50, 40, 60, 35};
      reset = 1'b1;
      start = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_action = '0;
      req_job_id = '0;
      req_now = '0;
      req_run_length = '0;
      req_prio = '0;
      req_evicted_valid = 1'b0;
      req_evicted_id = '0;
      idle_pct = 0;
      mismatches = 0;
      cycles = 0;
      m_policy = mpjs_pkg::POL_FCFS;
      m_turn = '0;
      m_wait = '0;
      m_resp = '0;
      m_seen = '0;
      gen_time = 32'd1000;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (ph = 0; ph < 10; ph++) begin
         write_policy(pols[ph]);
         idle_pct = idles[ph];
         if (ph == 0) begin
            // Directed: every action, floored differences, reuse and extremes.
            add_item(mpjs_pkg::ACT_QUANT, 0, 32'd5, '0, '0, 1'b0, 0);
            add_item(mpjs_pkg::ACT_NEW, 0, 32'd100, 32'd5, 16'd3, 1'b0, 0);
            add_item(mpjs_pkg::ACT_NEW, 1, 32'd200, 32'd3, 16'd3, 1'b1, 63);
            add_item(mpjs_pkg::ACT_NEW, 2, 32'd200, 32'd3, 16'hffff, 1'b0, 0);
            add_item(mpjs_pkg::ACT_QUANT, 0, 32'd210, '0, '0, 1'b0, 0);
            add_item(mpjs_pkg::ACT_QUANT, 0, 32'd150, '0, '0, 1'b1, 1);
            add_item(mpjs_pkg::ACT_QUANT, 0, 32'd400, '0, '0, 1'b1, 0);
            add_item(mpjs_pkg::ACT_QUANT, 0, 32'd999, '0, '0, 1'b1, 2);
            add_item(mpjs_pkg::ACT_FINISH, 1, 32'd0, '1, '1, 1'b1, 63);
            add_item(mpjs_pkg::ACT_NEW, 63, '1, '1, '1, 1'b1, 63);
            add_item(mpjs_pkg::ACT_FINISH, 63, '1, '0, '0, 1'b0, 0);
            add_item(mpjs_pkg::ACT_FINISH, 2, 32'd1000, '0, '0, 1'b0, 0);
            add_item(mpjs_pkg::ACT_NEW, 1, 32'd500, 32'd0, 16'd0, 1'b0, 0);
            add_item(mpjs_pkg::ACT_NEW, 1, 32'd500, 32'd0, 16'd0, 1'b0, 0);
            add_item(mpjs_pkg::ACT_FINISH, 1, 32'd700, '0, '0, 1'b0, 0);
            add_item(ACT_NONE, 63, '1, '1, '1, 1'b1, 63);
            add_item(mpjs_pkg::ACT_QUANT, 5, 32'd800, '0, '0, 1'b1, 63);
            add_item(mpjs_pkg::ACT_QUANT, 5, 32'd900, '0, '0, 1'b0, 0);
         end
         for (k = 0; k < 195; k++)
            add_random(news[ph], pols[ph] != mpjs_pkg::POL_PPRI &&
                                 pols[ph] != mpjs_pkg::POL_PSRTF &&
                                 pols[ph] != mpjs_pkg::POL_RR);
         drain();
      end
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("multi_policy_job_scheduler regression: pass");
      end else begin
         $display("multi_policy_job_scheduler regression: fail");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/mpjs_pkg.sv
hw/rtl/mpjs_ram.sv
hw/rtl/mpjs_cell.sv
hw/rtl/multi_policy_job_scheduler.sv
hw/rtl/mpjs_checker.sv
bench/tb.sv
